// ----- rtl/core/beas_pkg.sv -----
// Shared constants for the Bezier evaluation and antialiased splat unit.
package beas_pkg;

	// Fixed widths of the ports and of the configuration registers.
	localparam int TPARAM_W = 17;
	localparam int PIX_W    = 10;
	localparam int INT_W    = 8;
	localparam int REG_W    = 26;
	localparam int Y_LSB    = 16;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 5;

	// Register map: control points 0..5 at byte address 4*i.
	localparam int NUM_REGS   = 6;
	localparam int REG_POINT0 = 0;

	// Intensity gain, 255 / 0.75, and the saturation limit.
	localparam int SHADE_GAIN = 340;
	localparam int INT_MAX    = 255;

	// Index of the fourth and final write of one curve point.
	localparam logic [1:0] LAST_IDX = 2'd3;

endpackage

// ----- rtl/core/beas_cell.sv -----
// One de Casteljau level: a row of interpolation lanes with two register stages.
module beas_cell #(
	parameter int NP    = 6,
	parameter int LANES = 5,
	parameter int W     = 26,
	parameter int F     = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] px_i [NP],
	input  logic [W-1:0] py_i [NP],
	input  logic [F:0]   t_i,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] px_o [NP],
	output logic [W-1:0] py_o [NP],
	output logic [F:0]   t_o
);

	localparam int PW = W + F + 3;
	localparam logic signed [PW-1:0] HALF_P = PW'(1) << (F - 1);

	logic                 v_s1;
	logic                 v_s2;
	logic                 rdy2;
	logic                 ld1;
	logic                 ld2;
	logic signed [PW-1:0] prodx_s1 [LANES];
	logic signed [PW-1:0] prody_s1 [LANES];
	logic [W-1:0]         ax_s1 [LANES];
	logic [W-1:0]         ay_s1 [LANES];
	logic [F:0]           t_s1;
	logic [W-1:0]         nx_s2 [LANES];
	logic [W-1:0]         ny_s2 [LANES];
	logic [F:0]           t_s2;
	logic signed [F+1:0]  ts;

	assign rdy2     = !v_s2 || out_ready;
	assign in_ready = !v_s1 || rdy2;
	assign ld1      = in_valid && in_ready;
	assign ld2      = v_s1 && rdy2;
	assign ts       = $signed({1'b0, t_i});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			t_s1 <= t_i;
		end
		if (ld2) begin
			t_s2 <= t_s1;
		end
	end

	// Each lane forms a + round(t * (b - a)); the product is registered first.
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		logic signed [W:0]    dx;
		logic signed [W:0]    dy;
		logic signed [PW-1:0] mx;
		logic signed [PW-1:0] my;
		logic signed [PW-1:0] rx;
		logic signed [PW-1:0] ry;

		assign dx = $signed({1'b0, px_i[i+1]}) - $signed({1'b0, px_i[i]});
		assign dy = $signed({1'b0, py_i[i+1]}) - $signed({1'b0, py_i[i]});
		assign mx = dx * ts;
		assign my = dy * ts;
		assign rx = (prodx_s1[i] + HALF_P) >>> F;
		assign ry = (prody_s1[i] + HALF_P) >>> F;

		always_ff @(posedge clk) begin
			if (ld1) begin
				prodx_s1[i] <= mx;
				prody_s1[i] <= my;
				ax_s1[i]    <= px_i[i];
				ay_s1[i]    <= py_i[i];
			end
			if (ld2) begin
				nx_s2[i] <= ax_s1[i] + rx[W-1:0];
				ny_s2[i] <= ay_s1[i] + ry[W-1:0];
			end
		end

		assign px_o[i] = nx_s2[i];
		assign py_o[i] = ny_s2[i];
	end

	for (genvar i = LANES; i < NP; i++) begin : g_idle
		assign px_o[i] = '0;
		assign py_o[i] = '0;
	end

	assign out_valid = v_s2;
	assign t_o       = t_s2;

endmodule

// ----- rtl/core/beas_splat.sv -----
// Pixel rounding and the four antialiased writes around one curve point.
module beas_splat import beas_pkg::*; #(
	parameter int C = 10,
	parameter int F = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [C+F-1:0]   x_i,
	input  logic [C+F-1:0]   y_i,
	output logic             pix_valid,
	input  logic             pix_stall,
	output logic [PIX_W-1:0] pixel_x,
	output logic [PIX_W-1:0] pixel_y,
	output logic [INT_W-1:0] intensity,
	output logic             last_write
);

	localparam int W  = C + F;
	localparam int DW = F + 3;
	localparam int CW = C + 2;
	localparam int SW = F + 10;
	localparam logic signed [DW-1:0] ONE_D  = DW'(1) << F;
	localparam logic signed [DW-1:0] HALF_D = DW'(1) << (F - 1);
	localparam logic [CW-1:0]        CMAX   = CW'((1 << C) - 1);

	logic                 v_rnd_q;
	logic [C:0]           rx_s1;
	logic [C:0]           ry_s1;
	logic signed [DW-1:0] fx_s1;
	logic signed [DW-1:0] fy_s1;
	logic [1:0]           cnt_q;
	logic                 pix_valid_q;
	logic                 out_load;
	logic [W:0]           xh;
	logic [W:0]           yh;
	logic [CW-1:0]        oxw;
	logic [CW-1:0]        oyw;
	logic [CW-1:0]        ox_sat;
	logic [CW-1:0]        oy_sat;
	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic signed [DW-1:0] dmax;
	logic signed [DW-1:0] m;
	logic [SW-1:0]        sprod;
	logic [SW-F-1:0]      sval;
	logic [INT_W-1:0]     shade;

	assign xh = {1'b0, x_i} + ((W + 1)'(1) << (F - 1));
	assign yh = {1'b0, y_i} + ((W + 1)'(1) << (F - 1));

	assign out_load = v_rnd_q && (!pix_valid_q || !pix_stall);
	assign in_ready = !v_rnd_q || (out_load && cnt_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_rnd_q     <= 1'b0;
			cnt_q       <= 2'd0;
			pix_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_rnd_q <= in_valid;
			end
			if (out_load) begin
				cnt_q       <= cnt_q + 2'd1;
				pix_valid_q <= 1'b1;
			end else if (!pix_stall) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_s1 <= xh[W:F];
			ry_s1 <= yh[W:F];
			fx_s1 <= $signed(DW'(xh[F-1:0])) - HALF_D;
			fy_s1 <= $signed(DW'(yh[F-1:0])) - HALF_D;
		end
	end

	// Write order: the pixel, below, right, below-right.
	always_comb begin
		oxw    = CW'(rx_s1) + CW'(cnt_q[1]);
		oyw    = CW'(ry_s1) + CW'(cnt_q[0]);
		ox_sat = (oxw > CMAX) ? CMAX : oxw;
		oy_sat = (oyw > CMAX) ? CMAX : oyw;
		dx     = cnt_q[1] ? (ONE_D - fx_s1) : fx_s1;
		dy     = cnt_q[0] ? (ONE_D - fy_s1) : fy_s1;
		dmax   = (dx > dy) ? dx : dy;
		m      = ONE_D - dmax;
		sprod  = SW'(m[F:0]) * SW'(SHADE_GAIN);
		sval   = sprod[SW-1:F];
		if (m[DW-1] || m == '0) begin
			shade = '0;
		end else if (sval > (SW - F)'(INT_MAX)) begin
			shade = INT_W'(INT_MAX);
		end else begin
			shade = sval[INT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_x    <= PIX_W'(ox_sat);
			pixel_y    <= PIX_W'(oy_sat);
			intensity  <= shade;
			last_write <= (cnt_q == LAST_IDX);
		end
	end

	assign pix_valid = pix_valid_q;

endmodule

// ----- rtl/core/bezier_eval_antialias_splat_unit.sv -----
// Top level of the Bezier evaluation and antialiased splat unit.
// A curve point passes the registers of each interpolation cell, then the rounding and
// output registers of the splat; its other three writes follow one a cycle unless stalled.
// The four writes share the single result channel, so the splat takes the next point only
// as its last write loads; the cells themselves take a new value every cycle unless stalled.
// Reset clears every valid flag, the write counter and the control points to zero.
module bezier_eval_antialias_splat_unit import beas_pkg::*; #(
	parameter int NUM_POINTS = 6,
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// Control point registers.
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	// Curve parameter channel.
	input  logic                t_valid,
	output logic                t_stall,
	input  logic [TPARAM_W-1:0] t_param,
	// Pixel write channel.
	output logic                pix_valid,
	input  logic                pix_stall,
	output logic [PIX_W-1:0]    pixel_x,
	output logic [PIX_W-1:0]    pixel_y,
	output logic [INT_W-1:0]    intensity,
	output logic                last_write
);

	localparam int NP  = NUM_POINTS;
	localparam int C   = COORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int W   = C + F;
	localparam int TIW = (F + 1 > TPARAM_W) ? F + 1 : TPARAM_W;
	localparam logic [TIW-1:0] ONE_T = TIW'(1) << F;

	// The control points. Only the first six are writable; further points stay zero.
	logic [REG_W-1:0]  pt_q [NP];
	logic [2:0]        reg_idx;
	logic              wr_en;

	// The cell chain: index j holds the points that enter level j.
	logic              ch_valid [NP];
	logic              ch_ready [NP];
	logic [W-1:0]      ch_x [NP][NP];
	logic [W-1:0]      ch_y [NP][NP];
	logic [F:0]        ch_t [NP];
	logic [TIW-1:0]    t_ext;

	// A register write completes in the access phase; pready is tied high.
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	for (genvar i = 0; i < NP; i++) begin : g_pt
		logic [REG_W-1:0] ysh;

		if (i < NUM_REGS) begin : g_wr
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					pt_q[i] <= '0;
				end else if (wr_en && reg_idx == 3'(REG_POINT0 + i)) begin
					pt_q[i] <= pwdata[REG_W-1:0];
				end
			end
		end else begin : g_fixed
			assign pt_q[i] = '0;
		end

		// Coordinates enter the chain as fixed point with F fraction bits.
		assign ysh        = pt_q[i] >> Y_LSB;
		assign ch_x[0][i] = {pt_q[i][C-1:0], {F{1'b0}}};
		assign ch_y[0][i] = {ysh[C-1:0], {F{1'b0}}};
	end

	// A read of an address past the last control point returns zero.
	always_comb begin
		prdata = '0;
		for (int i = 0; i < NP; i++) begin
			if (i < NUM_REGS && reg_idx == 3'(REG_POINT0 + i)) begin
				prdata = DATA_W'(pt_q[i]);
			end
		end
	end

	// A parameter above one is treated as exactly one.
	assign t_ext       = TIW'(t_param);
	assign ch_t[0]     = (t_ext > ONE_T) ? ONE_T[F:0] : t_ext[F:0];
	assign ch_valid[0] = t_valid;
	assign t_stall     = !ch_ready[0];

	// Level j reduces NP-j points to NP-1-j; each cell has two register stages and
	// hands its points to the next cell as soon as that one can take them.
	for (genvar j = 0; j < NP - 1; j++) begin : g_lvl
		beas_cell #(
			.NP    (NP),
			.LANES (NP - 1 - j),
			.W     (W),
			.F     (F)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (ch_valid[j]),
			.in_ready  (ch_ready[j]),
			.px_i      (ch_x[j]),
			.py_i      (ch_y[j]),
			.t_i       (ch_t[j]),
			.out_valid (ch_valid[j+1]),
			.out_ready (ch_ready[j+1]),
			.px_o      (ch_x[j+1]),
			.py_o      (ch_y[j+1]),
			.t_o       (ch_t[j+1])
		);
	end

	// The curve point is rounded to a pixel and split into four writes. The output
	// register lets the next point wait in the rounding stage while a write is stalled.
	beas_splat #(
		.C (C),
		.F (F)
	) u_splat (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (ch_valid[NP-1]),
		.in_ready   (ch_ready[NP-1]),
		.x_i        (ch_x[NP-1][0]),
		.y_i        (ch_y[NP-1][0]),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.intensity  (intensity),
		.last_write (last_write)
	);

endmodule

// ----- rtl/core/beas_checker.sv -----
// Port-level checks on the pixel write channel, bound to the top level.
module beas_checker import beas_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             pix_valid,
	input logic             pix_stall,
	input logic [PIX_W-1:0] pixel_x,
	input logic [PIX_W-1:0] pixel_y,
	input logic [INT_W-1:0] intensity,
	input logic             last_write
);

	logic [1:0] ocnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= 2'd0;
		end else if (pix_valid && !pix_stall) begin
			ocnt_q <= ocnt_q + 2'd1;
		end
	end

	a_last_on_fourth: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> (last_write == (ocnt_q == LAST_IDX)))
		else $error("last_write does not mark the fourth write of a point");

	a_group_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && !pix_stall && !last_write) |=> pix_valid)
		else $error("gap inside the four writes of one point");

	a_column_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && !pix_stall && (ocnt_q == 2'd0 || ocnt_q == 2'd2))
		|=> (pixel_x == $past(pixel_x)))
		else $error("column changed between the two writes of one column");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_stall)
		|=> (pix_valid && $stable({pixel_x, pixel_y, intensity, last_write})))
		else $error("stalled pixel write changed");

endmodule

bind bezier_eval_antialias_splat_unit beas_checker u_beas_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pix_valid  (pix_valid),
	.pix_stall  (pix_stall),
	.pixel_x    (pixel_x),
	.pixel_y    (pixel_y),
	.intensity  (intensity),
	.last_write (last_write)
);
